### src/iq_phase_ramp_derotator_top_assert.svh
`ifndef IQ_PHASE_RAMP_DEROTATOR_TOP_ASSERT_SVH
`define IQ_PHASE_RAMP_DEROTATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IQPRD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IQPRD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/iqprd_pkg.sv
package iqprd_pkg;

	localparam int IN_W    = 8;
	localparam int OUT_W   = 11;
	localparam int PH_W    = 16;

	// Micro-rotation count, limited by the arctangent table length.
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_DEPTH    = 24;
	localparam int NSTG  = (CORDIC_STAGES < ATAN_DEPTH) ? CORDIC_STAGES : ATAN_DEPTH;
	localparam int K_W   = $clog2(NSTG);
	localparam int ATAN_AW = $clog2(ATAN_DEPTH);

	localparam int XY0_W  = IN_W + 1;
	localparam int FRAC_IN = 20;
	localparam int XY_W   = 32;
	localparam int Z_W    = 34;
	localparam int PROD_W = 64;

	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [XY0_W-1:0] x0;
		logic signed [XY0_W-1:0] y0;
		logic signed [PH_W-1:0]  rot;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t ent;
	} qpush_t;

	typedef struct packed {
		logic   valid;
		entry_t ent;
	} qhead_t;

	// atan(2^-k) in units of 2^-32 turn.
	function automatic logic signed [Z_W-1:0] atan_lut(input logic [ATAN_AW-1:0] k);
		logic signed [Z_W-1:0] a;
		case (k)
			5'd0:  a = 34'sd536870912;
			5'd1:  a = 34'sd316933406;
			5'd2:  a = 34'sd167458907;
			5'd3:  a = 34'sd85004756;
			5'd4:  a = 34'sd42667331;
			5'd5:  a = 34'sd21354465;
			5'd6:  a = 34'sd10679838;
			5'd7:  a = 34'sd5340245;
			5'd8:  a = 34'sd2670163;
			5'd9:  a = 34'sd1335087;
			5'd10: a = 34'sd667544;
			5'd11: a = 34'sd333772;
			5'd12: a = 34'sd166886;
			5'd13: a = 34'sd83443;
			5'd14: a = 34'sd41722;
			5'd15: a = 34'sd20861;
			5'd16: a = 34'sd10430;
			5'd17: a = 34'sd5215;
			5'd18: a = 34'sd2608;
			5'd19: a = 34'sd1304;
			5'd20: a = 34'sd652;
			5'd21: a = 34'sd326;
			5'd22: a = 34'sd163;
			5'd23: a = 34'sd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### src/iqprd_front.sv
module iqprd_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [iqprd_pkg::IN_W-1:0]      sample_i,
	input  logic signed [iqprd_pkg::IN_W-1:0]      sample_q,
	input  logic                                   last_in_block,
	input  logic                                   in_valid,
	input  logic                                   q_full,
	output logic                                   in_stall,
	input  logic                                   cfg_valid,
	input  logic [iqprd_pkg::PH_W-1:0]             cfg_data,
	output iqprd_pkg::qpush_t                      qpush
);
	import iqprd_pkg::*;

	logic [PH_W-1:0]         step_q;
	logic [PH_W-1:0]         ramp_q;
	logic [PH_W-1:0]         urot;
	logic signed [PH_W-1:0]  rot_s;
	logic                    flip;
	logic signed [XY0_W-1:0] xi;
	logic signed [XY0_W-1:0] yi;
	logic                    acc;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;

	// Rotate by minus the running phase; fold into the right half-plane.
	always_comb begin
		urot  = PH_W'(-ramp_q);
		rot_s = signed'(urot);
		flip  = (rot_s > 16'sd16384) || (rot_s < -16'sd16384);
		xi    = XY0_W'(sample_i);
		yi    = -XY0_W'(sample_q);
		qpush.push = acc;
		if (flip) begin
			qpush.ent.x0  = -xi;
			qpush.ent.y0  = -yi;
			qpush.ent.rot = signed'(urot ^ {1'b1, {(PH_W-1){1'b0}}});
		end else begin
			qpush.ent.x0  = xi;
			qpush.ent.y0  = yi;
			qpush.ent.rot = rot_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			ramp_q <= '0;
		end else begin
			if (cfg_valid) begin
				step_q <= cfg_data;
			end
			if (acc) begin
				ramp_q <= last_in_block ? '0 : PH_W'(ramp_q + step_q);
			end
		end
	end

endmodule

### src/iqprd_queue.sv
module iqprd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  iqprd_pkg::qpush_t  qpush,
	output logic               q_full,
	input  logic               pop,
	output iqprd_pkg::qhead_t  head
);
	import iqprd_pkg::*;

	entry_t          mem_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  cnt_q;
	logic            do_push;
	logic            do_pop;

	assign q_full     = (cnt_q == QCW'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.ent   = mem_q[rd_ptr_q];
	assign do_push    = qpush.push && !q_full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= qpush.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : QAW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : QAW'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= QCW'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= QCW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

### src/iqprd_back.sv
module iqprd_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  iqprd_pkg::qhead_t                     head,
	output logic                                  pop,
	output logic signed [iqprd_pkg::OUT_W-1:0]    out_i,
	output logic signed [iqprd_pkg::OUT_W-1:0]    out_q,
	output logic                                  out_valid,
	input  logic                                  out_stall
);
	import iqprd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ITER = 3'd1;
	localparam logic [2:0] ST_MULX = 3'd2;
	localparam logic [2:0] ST_MULY = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic signed [PROD_W-1:0] GAIN_Q30 = 64'sd652032874;
	localparam logic signed [PROD_W-1:0] RND_HALF = 64'sd140737488355328;

	logic [2:0]               st_q;
	logic [K_W-1:0]           k_q;
	logic signed [XY_W-1:0]   x_q;
	logic signed [XY_W-1:0]   y_q;
	logic signed [Z_W-1:0]    z_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [OUT_W-1:0]  rx_q;
	logic signed [OUT_W-1:0]  oi_q;
	logic signed [OUT_W-1:0]  oq_q;
	logic                     ov_q;
	logic signed [XY_W-1:0]   dx;
	logic signed [XY_W-1:0]   dy;
	logic signed [Z_W-1:0]    ang;
	logic signed [XY_W-1:0]   mul_a;
	logic signed [PROD_W-1:0] mul_p;
	logic                     out_free;

	// Round half up, drop 48 fraction bits, clamp to the output range.
	function automatic logic signed [OUT_W-1:0] rnd_clamp(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		logic signed [15:0]       r;
		s = p + RND_HALF;
		r = signed'(s[PROD_W-1:48]);
		if (r > 16'sd725) begin
			r = 16'sd725;
		end else if (r < -16'sd725) begin
			r = -16'sd725;
		end
		return r[OUT_W-1:0];
	endfunction

	assign pop       = (st_q == ST_IDLE) && head.valid;
	assign out_free  = !ov_q || !out_stall;
	assign out_i     = oi_q;
	assign out_q     = oq_q;
	assign out_valid = ov_q;

	assign dx    = y_q >>> k_q;
	assign dy    = x_q >>> k_q;
	assign ang   = atan_lut(ATAN_AW'(k_q));
	assign mul_a = (st_q == ST_MULX) ? x_q : y_q;
	assign mul_p = PROD_W'(mul_a) * GAIN_Q30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q  <= '0;
			ov_q <= 1'b0;
		end else begin
			if ((st_q == ST_FIN) && out_free) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (head.valid) begin
						k_q  <= '0;
						st_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					if (k_q == K_W'(NSTG - 1)) begin
						st_q <= ST_MULX;
					end else begin
						k_q <= K_W'(k_q + 1'b1);
					end
				end
				ST_MULX: st_q <= ST_MULY;
				ST_MULY: st_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				x_q <= XY_W'(head.ent.x0) <<< FRAC_IN;
				y_q <= XY_W'(head.ent.y0) <<< FRAC_IN;
				z_q <= Z_W'(head.ent.rot) <<< PH_W;
			end
			ST_ITER: begin
				if (!z_q[Z_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - ang;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + ang;
				end
			end
			ST_MULX: prod_q <= mul_p;
			ST_MULY: begin
				rx_q   <= rnd_clamp(prod_q);
				prod_q <= mul_p;
			end
			ST_FIN: begin
				if (out_free) begin
					oi_q <= rx_q;
					oq_q <= rnd_clamp(prod_q);
				end
			end
			default: ;
		endcase
	end

endmodule

### src/iq_phase_ramp_derotator_top.sv
// I/Q phase-ramp derotator. Each signed 8-bit sample (sample_i, sample_q) is
// conjugated and rotated by minus n times phase_step, where n counts samples
// since reset or since the last sample marked last_in_block; out_i/out_q keep
// the magnitude and carry two fraction bits (values stay within +/-725, no
// saturation occurs). phase_step is a two's complement turn fraction in units
// of 2*pi/65536, written through the cfg_valid/cfg_ready/cfg_data channel,
// which is always ready; write it only while no transaction is in flight.
// Timing: the front end takes a sample in the cycle it arrives and parks it in
// a two-entry queue, so in_stall rises only when that queue is full. The back
// end serves one sample at a time: it loads the sample, runs the micro-rotations
// one after another on the shared shift-add unit, scales X and then Y on the
// shared gain multiplier, and rounds and hands the result to the output
// register. A result waiting on out_stall holds only the back end; the front
// end keeps taking samples until the queue fills.
module iq_phase_ramp_derotator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [iqprd_pkg::IN_W-1:0]    sample_i,
	input  logic signed [iqprd_pkg::IN_W-1:0]    sample_q,
	input  logic                                 last_in_block,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	output logic signed [iqprd_pkg::OUT_W-1:0]   out_i,
	output logic signed [iqprd_pkg::OUT_W-1:0]   out_q,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [iqprd_pkg::PH_W-1:0]           cfg_data
);
	import iqprd_pkg::*;

	qpush_t qpush;
	qhead_t head;
	logic   q_full;
	logic   pop;

	// The step register never back-pressures a write.
	assign cfg_ready = 1'b1;

	// Front end: classify the sample against the running phase and advance it.
	iqprd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_i      (sample_i),
		.sample_q      (sample_q),
		.last_in_block (last_in_block),
		.in_valid      (in_valid),
		.q_full        (q_full),
		.in_stall      (in_stall),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.qpush         (qpush)
	);

	// Decouple the two halves.
	iqprd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.q_full (q_full),
		.pop    (pop),
		.head   (head)
	);

	// Back end: iterate the rotation, apply the gain, hold the result.
	iqprd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_i     (out_i),
		.out_q     (out_q),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule

### src/iqprd_checker.sv
`include "iq_phase_ramp_derotator_top_assert.svh"

module iqprd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic signed [iqprd_pkg::OUT_W-1:0]   out_i,
	input logic signed [iqprd_pkg::OUT_W-1:0]   out_q,
	input logic                                 out_valid,
	input logic                                 out_stall
);
	import iqprd_pkg::*;

	localparam int MAX_INFL = QDEPTH + 2;
	localparam int CNT_W    = $clog2(MAX_INFL + 1);

	logic [CNT_W-1:0] infl_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Track accepted samples not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q <= '0;
		end else begin
			infl_q <= CNT_W'(infl_q + CNT_W'(in_acc) - CNT_W'(out_acc));
		end
	end

	`IQPRD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_i) && $stable(out_q), "stalled result changed")
	`IQPRD_ASSERT_IMP(a_out_range, clk, arst_n, out_valid, out_i <= 11'sd725 && out_i >= -11'sd725 && out_q <= 11'sd725 && out_q >= -11'sd725, "result out of range")
	`IQPRD_ASSERT_IMP(a_no_phantom, clk, arst_n, out_valid, infl_q != '0, "result without an accepted sample")
	`IQPRD_ASSERT_IMP(a_infl_bound, clk, arst_n, 1'b1, infl_q <= CNT_W'(MAX_INFL), "too many samples in flight")

endmodule

bind iq_phase_ramp_derotator_top iqprd_checker u_iqprd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_i     (out_i),
	.out_q     (out_q),
	.out_valid (out_valid),
	.out_stall (out_stall)
);
